### rtl/sbpd_pkg.sv
// Package for the seven-bit packet decoder: field widths, protocol codes,
// scaling constants and the sample type passed from the cell row to the scaler.
// No dependencies.
package sbpd_pkg;

    // Byte and packet layout.
    localparam int BYTE_W  = 8;
    localparam int DATA_W  = 7;
    localparam int PKT_LEN = 7;
    localparam int PKT_W   = DATA_W * PKT_LEN;
    localparam int CNT_W   = 3;

    // Received byte codes.
    localparam logic [BYTE_W-1:0] CMD_DECODE = 8'h84;
    localparam int                CMD_BIT    = 7;

    // Positions of the decoded fields in the 49-bit packet string.
    localparam int WORD_W   = 16;
    localparam int WORD_LSB = 24;
    localparam int GAS_W    = 8;
    localparam int GAS_LSB  = 16;
    localparam int BATT_W   = 8;
    localparam int BATT_LSB = 0;

    // Result widths and bounds.
    localparam int RPM_W = 12;
    localparam int BAT_W = 11;
    localparam logic [RPM_W-1:0] RPM_MAX = 12'd3352;
    localparam logic [BAT_W-1:0] BAT_MAX = 11'd1304;

    // Scale factors. Division uses a truncated reciprocal plus one correction step.
    localparam int RPM_MUL     = 100;
    localparam int RPM_DIV     = 1955;
    localparam int BAT_MUL     = 5115;
    localparam int BAT_DIV     = 1000;
    localparam int RECIP_SHIFT = 32;
    localparam int PROD_RPM_W  = 23;
    localparam int PROD_BAT_W  = 21;
    localparam int RPM_RECIP_W = 22;
    localparam int BAT_RECIP_W = 23;
    localparam logic [RPM_RECIP_W-1:0] RPM_RECIP =
        RPM_RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(RPM_DIV));
    localparam logic [BAT_RECIP_W-1:0] BAT_RECIP =
        BAT_RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(BAT_DIV));

    // Raw fields of one completed packet.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [GAS_W-1:0]  gas;
        logic [BATT_W-1:0] batt;
    } sbpd_sample_t;

endpackage

### rtl/sbpd_cell.sv
// One storage cell of the data byte chain: holds a 7-bit data byte and passes
// it on to its neighbor whenever the chain shifts. Depends on sbpd_pkg.
module sbpd_cell (
    input  logic                       aclk,
    input  logic                       shift_en,
    input  logic [sbpd_pkg::DATA_W-1:0] d_in,
    output logic [sbpd_pkg::DATA_W-1:0] q
);
    import sbpd_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Take the neighbor's byte on a shift, otherwise hold.
    always_comb begin
        data_next = shift_en ? d_in : data_reg;
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

### rtl/sbpd_scale.sv
// Three-stage scaling pipeline: multiplies the speed word and battery byte by
// their factors, divides by reciprocal multiplication and corrects the quotient.
// Depends on sbpd_pkg.
module sbpd_scale (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  sbpd_pkg::sbpd_sample_t        in_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sbpd_pkg::RPM_W-1:0]    m_rpm_code,
    output logic [sbpd_pkg::GAS_W-1:0]    m_gas_temp,
    output logic [sbpd_pkg::BAT_W-1:0]    m_battery_code
);
    import sbpd_pkg::*;

    localparam int FULL_RPM_W = PROD_RPM_W + RPM_RECIP_W;
    localparam int FULL_BAT_W = PROD_BAT_W + BAT_RECIP_W;

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    logic [PROD_RPM_W-1:0] prod_rpm_reg, prod_rpm_next, prod_rpm2_reg;
    logic [PROD_BAT_W-1:0] prod_bat_reg, prod_bat_next, prod_bat2_reg;
    logic [GAS_W-1:0]      gas1_reg, gas2_reg, gas3_reg;
    logic [RPM_W-1:0]      est_rpm_reg, est_rpm_next, rpm_reg, rpm_next;
    logic [BAT_W-1:0]      est_bat_reg, est_bat_next, bat_reg, bat_next;
    logic [FULL_RPM_W-1:0] full_rpm;
    logic [FULL_BAT_W-1:0] full_bat;
    logic [PROD_RPM_W-1:0] back_rpm, rem_rpm;
    logic [PROD_BAT_W-1:0] back_bat, rem_bat;

    // A stage loads when it is empty or its contents move on.
    assign en3      = !v3_reg || m_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Stage 1: scale factor products.
    always_comb begin
        prod_rpm_next = PROD_RPM_W'(in_sample.word) * PROD_RPM_W'(RPM_MUL);
        prod_bat_next = PROD_BAT_W'(in_sample.batt) * PROD_BAT_W'(BAT_MUL);
    end

    // Stage 2: quotient estimate, at most one below the true quotient.
    always_comb begin
        full_rpm     = FULL_RPM_W'(prod_rpm_reg) * FULL_RPM_W'(RPM_RECIP);
        full_bat     = FULL_BAT_W'(prod_bat_reg) * FULL_BAT_W'(BAT_RECIP);
        est_rpm_next = full_rpm[RECIP_SHIFT +: RPM_W];
        est_bat_next = full_bat[RECIP_SHIFT +: BAT_W];
    end

    // Stage 3: remainder check bumps the estimate when it fell one short.
    always_comb begin
        back_rpm = PROD_RPM_W'(est_rpm_reg) * PROD_RPM_W'(RPM_DIV);
        back_bat = PROD_BAT_W'(est_bat_reg) * PROD_BAT_W'(BAT_DIV);
        rem_rpm  = prod_rpm2_reg - back_rpm;
        rem_bat  = prod_bat2_reg - back_bat;
        rpm_next = (rem_rpm >= PROD_RPM_W'(RPM_DIV)) ? est_rpm_reg + 1'b1 : est_rpm_reg;
        bat_next = (rem_bat >= PROD_BAT_W'(BAT_DIV)) ? est_bat_reg + 1'b1 : est_bat_reg;
    end

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            prod_rpm_reg <= prod_rpm_next;
            prod_bat_reg <= prod_bat_next;
            gas1_reg     <= in_sample.gas;
        end
        if (en2 && v1_reg) begin
            est_rpm_reg   <= est_rpm_next;
            est_bat_reg   <= est_bat_next;
            prod_rpm2_reg <= prod_rpm_reg;
            prod_bat2_reg <= prod_bat_reg;
            gas2_reg      <= gas1_reg;
        end
        if (en3 && v2_reg) begin
            rpm_reg  <= rpm_next;
            bat_reg  <= bat_next;
            gas3_reg <= gas2_reg;
        end
    end

    assign m_valid        = v3_reg;
    assign m_rpm_code     = rpm_reg;
    assign m_gas_temp     = gas3_reg;
    assign m_battery_code = bat_reg;

    // The corrected quotients stay within their ranges.
    a_rpm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_rpm_code <= RPM_MAX)
        else $error("speed result out of range");

    a_bat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_battery_code <= BAT_MAX)
        else $error("battery result out of range");

    // Input back-pressure only when every stage holds a result.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> v1_reg && v2_reg && v3_reg && !m_ready)
        else $error("pipeline stalled while not full");

endmodule

### rtl/seven_bit_packet_decoder.sv
// Top level of the seven-bit packet decoder: command tracking, a row of data
// byte cells and the scaling pipeline. Depends on sbpd_pkg, sbpd_cell, sbpd_scale.
//
//  Channel   Ports                                       Direction
//  input     s_valid, s_ready, s_rx_byte                 in (one received byte)
//  result    m_valid, m_ready, m_rpm_code, m_gas_temp,   out (one decoded packet)
//            m_battery_code
//
// One byte is taken per cycle while s_ready is high. A result passes through the
// three-stage scaling pipeline (multiply, reciprocal multiply, remainder correction)
// after the transfer of the seventh data byte of a command 0x84 packet.
// Reset is synchronous and active low; it clears the active command, the data
// count and the pipeline valid flags. s_ready drops only when all three
// pipeline stages hold results and the result channel is stalled.
module seven_bit_packet_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sbpd_pkg::BYTE_W-1:0]   s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sbpd_pkg::RPM_W-1:0]    m_rpm_code,
    output logic [sbpd_pkg::GAS_W-1:0]    m_gas_temp,
    output logic [sbpd_pkg::BAT_W-1:0]    m_battery_code
);
    import sbpd_pkg::*;

    // The last byte of a packet is decoded straight from the input, so the
    // row holds one cell fewer than the packet length.
    localparam int NCELLS = PKT_LEN - 1;

    logic                 accept;
    logic                 is_cmd;
    logic                 cmd_active;
    logic                 shift_en;
    logic                 pkt_close;
    logic                 launch;
    logic [BYTE_W-1:0]    active_command_reg, active_command_next;
    logic [CNT_W-1:0]     data_count_reg, data_count_next;
    logic [DATA_W-1:0]    cell_q [NCELLS];
    logic [PKT_W-1:0]     pkt_bits;
    sbpd_sample_t         sample;
    logic                 scale_ready;

    assign accept     = s_valid && s_ready;
    assign is_cmd     = s_rx_byte[CMD_BIT];
    assign cmd_active = active_command_reg[CMD_BIT];
    assign shift_en   = accept && !is_cmd && cmd_active;
    assign pkt_close  = shift_en && (data_count_reg == CNT_W'(PKT_LEN - 1));
    assign launch     = pkt_close && (active_command_reg == CMD_DECODE);
    assign s_ready    = scale_ready;

    // Command and data count update.
    always_comb begin
        active_command_next = active_command_reg;
        data_count_next     = data_count_reg;
        if (accept && is_cmd) begin
            active_command_next = s_rx_byte;
            data_count_next     = '0;
        end else if (pkt_close) begin
            data_count_next = '0;
        end else if (shift_en) begin
            data_count_next = data_count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_command_reg <= '0;
            data_count_reg     <= '0;
        end else begin
            active_command_reg <= active_command_next;
            data_count_reg     <= data_count_next;
        end
    end

    // Row of data cells; new bytes enter cell 0 and move toward the far end.
    for (genvar i = 0; i < NCELLS; i++) begin : g_cell
        if (i == 0) begin : g_head
            sbpd_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .d_in     (s_rx_byte[DATA_W-1:0]),
                .q        (cell_q[i])
            );
        end else begin : g_body
            sbpd_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .d_in     (cell_q[i-1]),
                .q        (cell_q[i])
            );
        end
    end

    // Packet string, first byte most significant; the oldest byte sits in the
    // last cell and the closing byte comes from the input.
    always_comb begin
        pkt_bits[DATA_W-1:0] = s_rx_byte[DATA_W-1:0];
        for (int k = 0; k < NCELLS; k++) begin
            pkt_bits[DATA_W*(k+1) +: DATA_W] = cell_q[k];
        end
    end

    always_comb begin
        sample.word = pkt_bits[WORD_LSB +: WORD_W];
        sample.gas  = pkt_bits[GAS_LSB +: GAS_W];
        sample.batt = pkt_bits[BATT_LSB +: BATT_W];
    end

    sbpd_scale u_scale (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (launch),
        .in_ready       (scale_ready),
        .in_sample      (sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rpm_code     (m_rpm_code),
        .m_gas_temp     (m_gas_temp),
        .m_battery_code (m_battery_code)
    );

    // The data count never passes the last slot of a packet.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        data_count_reg <= CNT_W'(PKT_LEN - 1))
        else $error("data count overran the packet");

    // A command transfer always restarts the packet.
    a_cmd_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_cmd |=> data_count_reg == '0 && active_command_reg == $past(s_rx_byte))
        else $error("command did not restart the packet");

    // Data with no active command leaves the count alone.
    a_drop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_cmd && !cmd_active |=> $stable(data_count_reg))
        else $error("data byte counted with no active command");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for seven_bit_packet_decoder: drives received bytes, decodes them in
// a local copy of the packet logic and checks every result transfer. Depends on sbpd_pkg.
module tb_top;
    import sbpd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 20;
    localparam int REPORT_MAX   = 10;
    localparam int RANDOM_ITEMS = 775;

    // One decoded packet as the result channel carries it.
    typedef struct packed {
        logic [RPM_W-1:0] rpm;
        logic [GAS_W-1:0] gas;
        logic [BAT_W-1:0] batt;
    } decoded_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_rx_byte = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [RPM_W-1:0]  m_rpm_code;
    logic [GAS_W-1:0]  m_gas_temp;
    logic [BAT_W-1:0]  m_battery_code;

    // Local copy of the decoder state.
    logic [BYTE_W-1:0] active_cmd = '0;
    logic [CNT_W-1:0]  data_cnt   = '0;
    logic [DATA_W-1:0] data_row [PKT_LEN];

    decoded_t pending_decodes[$];
    int       fail_count    = 0;
    int       items_sent    = 0;
    int       cycle_count   = 0;
    int       hold_requests = 0;
    bit       feed_gapless  = 1'b0;
    bit       sink_gapless  = 1'b0;

    seven_bit_packet_decoder dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rpm_code     (m_rpm_code),
        .m_gas_temp     (m_gas_temp),
        .m_battery_code (m_battery_code)
    );

    // Clock with a 4 ns period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Data byte with the edge values favored.
    function automatic logic [BYTE_W-1:0] rand_data();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'h7f;
        return BYTE_W'($urandom_range(0, 127));
    endfunction

    // Any command byte except the decoded one.
    function automatic logic [BYTE_W-1:0] other_cmd();
        logic [BYTE_W-1:0] c;
        do begin
            c = {1'b1, 7'($urandom_range(0, 127))};
        end while (c == CMD_DECODE);
        return c;
    endfunction

    // Update the local state for one accepted byte and queue the decoded packet if one closes.
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic [PKT_W-1:0]  bits;
        logic [WORD_W-1:0] word;
        logic [BATT_W-1:0] batt;
        int unsigned       wide;
        decoded_t          d;
        if (b[CMD_BIT]) begin
            active_cmd = b;
            data_cnt   = '0;
            return;
        end
        if (!active_cmd[CMD_BIT]) return;
        data_row[data_cnt] = b[DATA_W-1:0];
        if (data_cnt != CNT_W'(PKT_LEN - 1)) begin
            data_cnt = data_cnt + 1'b1;
            return;
        end
        data_cnt = '0;
        if (active_cmd != CMD_DECODE) return;

        // Join the seven 7-bit bytes MSB first, then pick the fields.
        bits = '0;
        for (int k = 0; k < PKT_LEN; k++) begin
            bits = {bits[PKT_W-DATA_W-1:0], data_row[k]};
        end
        word  = bits[WORD_LSB +: WORD_W];
        d.gas = bits[GAS_LSB +: GAS_W];
        batt  = bits[BATT_LSB +: BATT_W];
        wide   = word;
        d.rpm  = RPM_W'((wide * RPM_MUL) / RPM_DIV);
        wide   = batt;
        d.batt = BAT_W'((wide * BAT_MUL) / BAT_DIV);
        pending_decodes.push_back(d);
    endtask

    // Offer one byte and hold it until the transfer.
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        int gap;
        gap = feed_gapless ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= value;
        do @(posedge aclk); while (!s_ready);
        decode_byte(value);
        items_sent++;
    endtask

    // A command followed by a number of random data bytes.
    task automatic send_packet(input logic [BYTE_W-1:0] cmd, input int n_data);
        send_byte(cmd);
        repeat (n_data) send_byte(rand_data());
    endtask

    // Stop offering bytes until every queued result has arrived or the wait limit is reached.
    task automatic wait_for_drain(input int limit);
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
            waited++;
        end while (pending_decodes.size() != 0 && waited < limit);
    endtask

    // Compare one result transfer with the oldest queued packet.
    task automatic check_result();
        decoded_t want;
        if (pending_decodes.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("unexpected result: rpm %0d gas %0d battery %0d",
                         m_rpm_code, m_gas_temp, m_battery_code);
            return;
        end
        want = pending_decodes.pop_front();
        if (m_rpm_code !== want.rpm || m_gas_temp !== want.gas ||
            m_battery_code !== want.batt) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("mismatch: expected rpm %0d gas %0d battery %0d, got %0d %0d %0d",
                         want.rpm, want.gas, want.batt,
                         m_rpm_code, m_gas_temp, m_battery_code);
        end
    endtask

    // Result side: checks each transfer and drives m_ready with random and requested stalls.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        int holds_done;
        stall_left = 0;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) check_result();
            if (holds_done != hold_requests) begin
                hold_left  = HOLD_CYCLES;
                holds_done = hold_requests;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!sink_gapless) stall_left = idle_len();
            end
        end
    end

    // Right after reset no command is active, so data bytes must be dropped.
    task automatic test_data_without_command();
        send_byte(8'h00);
        send_byte(8'h7f);
    endtask

    // A completed packet under a command other than 0x84 gives no result.
    task automatic test_other_command();
        send_byte(8'hff);
        repeat (PKT_LEN) send_byte(8'h2a);
    endtask

    // Two data bytes start a packet that the next command must abandon.
    task automatic test_command_mid_packet();
        send_byte(8'h55);
        send_byte(8'h2a);
    endtask

    // All-zero and all-one packets; the second runs on without a new command.
    task automatic test_field_extremes();
        send_byte(CMD_DECODE);
        repeat (PKT_LEN) send_byte(8'h00);
        repeat (PKT_LEN) send_byte(8'h7f);
    endtask

    // The result side holds off while packets keep arriving back to back, then a full drain.
    task automatic test_backpressure();
        hold_requests <= hold_requests + 1;
        feed_gapless = 1'b1;
        repeat (6) send_packet(CMD_DECODE, PKT_LEN);
        feed_gapless = 1'b0;
        wait_for_drain(DRAIN_LIMIT);
    endtask

    // Mostly well-formed packets with random content, plus broken packets and noise.
    task automatic test_random_traffic();
        int target;
        int kind;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            if ($urandom_range(0, 15) == 0) feed_gapless = !feed_gapless;
            if ($urandom_range(0, 15) == 0) sink_gapless = !sink_gapless;
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                send_packet(CMD_DECODE, PKT_LEN);
            end else if (kind < 68) begin
                repeat (PKT_LEN) send_byte(rand_data());
            end else if (kind < 78) begin
                send_packet(other_cmd(), PKT_LEN);
            end else if (kind < 90) begin
                send_packet(($urandom_range(0, 1) != 0) ? CMD_DECODE : other_cmd(),
                            $urandom_range(0, PKT_LEN - 1));
            end else if (kind < 97) begin
                repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(0, 255)));
            end else begin
                wait_for_drain(DRAIN_LIMIT);
            end
        end
        feed_gapless = 1'b0;
        sink_gapless = 1'b0;
    endtask

    // Test sequence and final verdict.
    initial begin : main_flow
        for (int k = 0; k < PKT_LEN; k++) data_row[k] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_data_without_command();
        test_other_command();
        test_command_mid_packet();
        test_field_extremes();
        test_backpressure();
        test_random_traffic();

        wait_for_drain(DRAIN_LIMIT);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_decodes.size() != 0) begin
            $display("%0d expected results never arrived", pending_decodes.size());
            fail_count += pending_decodes.size();
        end
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### files.f
rtl/sbpd_pkg.sv
rtl/sbpd_cell.sv
rtl/sbpd_scale.sv
rtl/seven_bit_packet_decoder.sv
bench/tb_top.sv
